>>> hw/rtl/tsgc_pkg.sv
// Shared types, codes and reset values for the two-sided game clock.
package tsgc_pkg;

    localparam int unsigned TIME_BITS_DEF = 32;
    localparam int unsigned MILLIS_IN_SEC = 1000;
    localparam int unsigned MILLIS_IN_MIN = 60 * MILLIS_IN_SEC;

    localparam logic        RST_TIME_CTRL = 1'b1;
    localparam logic [31:0] RST_INIT_MS   = 32'(3 * MILLIS_IN_MIN);
    localparam logic [31:0] RST_INC_MS    = 32'(2 * MILLIS_IN_SEC);

    localparam int unsigned ADDR_BITS = 4;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_TIME_CTRL = 2'd0;
    localparam logic [1:0] REG_INIT_MS   = 2'd1;
    localparam logic [1:0] REG_INC_MS    = 2'd2;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_SWITCH = 3'd1;
    localparam logic [2:0] MODE_INC    = 3'd2;
    localparam logic [2:0] MODE_PAUSE  = 3'd3;
    localparam logic [2:0] MODE_RESUME = 3'd4;
    localparam logic [2:0] MODE_START  = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
        logic        side;
    } t_in;

    typedef struct packed {
        logic [31:0] white_left_ms;
        logic [31:0] black_left_ms;
        logic        running_side;
        logic        is_paused;
        logic        white_fell;
        logic        black_fell;
        logic        timed_game;
    } t_out;

    typedef struct packed {
        logic        time_ctrl;
        logic [31:0] init_ms;
        logic [31:0] inc_ms;
    } t_cfg;

endpackage

>>> hw/rtl/tsgc_cfg.sv
// APB register file: time control enable, initial time and increment.
module tsgc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsgc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tsgc_pkg::t_cfg                o_cfg
);

    tsgc_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_ctrl <= tsgc_pkg::RST_TIME_CTRL;
            r_cfg.init_ms   <= tsgc_pkg::RST_INIT_MS;
            r_cfg.inc_ms    <= tsgc_pkg::RST_INC_MS;
        end else if (wr_en) begin
            unique case (reg_idx)
                tsgc_pkg::REG_TIME_CTRL: r_cfg.time_ctrl <= pwdata[0];
                tsgc_pkg::REG_INIT_MS:   r_cfg.init_ms   <= pwdata;
                tsgc_pkg::REG_INC_MS:    r_cfg.inc_ms    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tsgc_pkg::REG_TIME_CTRL: prdata = {31'd0, r_cfg.time_ctrl};
            tsgc_pkg::REG_INIT_MS:   prdata = r_cfg.init_ms;
            tsgc_pkg::REG_INC_MS:    prdata = r_cfg.inc_ms;
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

>>> hw/rtl/two_side_game_clock.sv
// Top level of the two-sided countdown game clock with Fischer increment.
//
// Usage: one event beat on the input channel (mode, now_ms, side) gives
// exactly one result beat on the output channel with both remaining times,
// the running side, the paused mark, both flag-fall marks and the timed mark
// as they stand after the event. Events are applied in acceptance order.
// Pipeline: an input register, then one pass of compare/subtract/add logic
// into the state and result registers, which also hold the result beat.
// Throughput is one event per cycle while the receiver does not stall; the
// state update of one event is visible to the event in the next cycle.
// When the receiver stalls, the result register holds its beat and the
// input register can still take one more beat; after that o_in_stall rises.
// Reset clears the game state (untimed, not paused, white running, times
// zero) and loads the configuration registers with their defaults: timed
// games on, 3 minutes initial time, 2 seconds increment. Configuration is
// written through the APB port, one register per 32-bit word.
module two_side_game_clock #(
    parameter int unsigned TIME_BITS = tsgc_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tsgc_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tsgc_pkg::t_out                 o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsgc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    tsgc_pkg::t_cfg cfg;

    tsgc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register
    logic          r_in_valid;
    tsgc_pkg::t_in r_in;
    // result register
    logic           r_out_valid;
    tsgc_pkg::t_out r_out;
    // game state
    logic                 r_timed, n_timed;
    logic                 r_halted, n_halted;
    logic                 r_act, n_act;
    logic [TIME_BITS-1:0] r_stamp, n_stamp;
    logic [TIME_BITS-1:0] r_left_w, n_left_w;
    logic [TIME_BITS-1:0] r_left_b, n_left_b;
    logic                 r_fell_w, n_fell_w;
    logic                 r_fell_b, n_fell_b;

    logic                 advance;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] run_left;
    logic                 run_fell;
    logic [TIME_BITS-1:0] inc_t;
    logic [TIME_BITS-1:0] init_t;
    logic [TIME_BITS-1:0] inc_left;
    logic                 inc_fell;
    logic [TIME_BITS:0]   inc_sum;
    logic [TIME_BITS-1:0] inc_res;
    logic                 charge_en;
    logic [TIME_BITS-1:0] chg_left;
    logic                 chg_fell;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign now_t    = TIME_BITS'(r_in.now_ms);
    assign inc_t    = TIME_BITS'(cfg.inc_ms);
    assign init_t   = TIME_BITS'(cfg.init_ms);
    assign elapsed  = now_t - r_stamp;
    assign run_left = r_act ? r_left_b : r_left_w;
    assign run_fell = r_act ? r_fell_b : r_fell_w;
    assign inc_left = r_in.side ? r_left_b : r_left_w;
    assign inc_fell = r_in.side ? r_fell_b : r_fell_w;
    assign inc_sum  = {1'b0, inc_left} + {1'b0, inc_t};
    // saturate on carry out
    assign inc_res  = inc_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : inc_sum[TIME_BITS-1:0];

    // charge of elapsed time to the running side
    always_comb begin
        chg_left = run_left;
        chg_fell = run_fell;
        if (elapsed != '0 && !run_fell) begin
            if (elapsed >= run_left) begin
                chg_left = '0;
                chg_fell = 1'b1;
            end else begin
                chg_left = run_left - elapsed;
            end
        end
    end

    always_comb begin
        n_timed  = r_timed;
        n_halted = r_halted;
        n_act    = r_act;
        n_stamp  = r_stamp;
        n_left_w = r_left_w;
        n_left_b = r_left_b;
        n_fell_w = r_fell_w;
        n_fell_b = r_fell_b;

        charge_en = r_timed && !r_halted &&
                    (r_in.mode == tsgc_pkg::MODE_TICK ||
                     r_in.mode == tsgc_pkg::MODE_SWITCH ||
                     r_in.mode == tsgc_pkg::MODE_PAUSE);
        if (charge_en) begin
            n_stamp = now_t;
            if (r_act) begin
                n_left_b = chg_left;
                n_fell_b = chg_fell;
            end else begin
                n_left_w = chg_left;
                n_fell_w = chg_fell;
            end
        end

        unique case (r_in.mode)
            tsgc_pkg::MODE_SWITCH: begin
                if (r_timed) begin
                    n_act   = !r_act;
                    n_stamp = now_t;
                end
            end
            tsgc_pkg::MODE_INC: begin
                if (r_timed && !inc_fell) begin
                    if (r_in.side) begin
                        n_left_b = inc_res;
                    end else begin
                        n_left_w = inc_res;
                    end
                end
            end
            tsgc_pkg::MODE_PAUSE: begin
                if (r_timed && !r_halted) begin
                    n_halted = 1'b1;
                end
            end
            tsgc_pkg::MODE_RESUME: begin
                if (r_timed && r_halted) begin
                    n_halted = 1'b0;
                    n_stamp  = now_t;
                end
            end
            tsgc_pkg::MODE_START: begin
                n_halted = 1'b0;
                n_fell_w = 1'b0;
                n_fell_b = 1'b0;
                if (cfg.time_ctrl) begin
                    n_timed  = 1'b1;
                    n_act    = r_in.side;
                    n_stamp  = now_t;
                    n_left_w = init_t;
                    n_left_b = init_t;
                end else begin
                    n_timed  = 1'b0;
                    n_act    = 1'b0;
                    n_stamp  = '0;
                    n_left_w = '0;
                    n_left_b = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_timed     <= 1'b0;
            r_halted    <= 1'b0;
            r_act       <= 1'b0;
            r_stamp     <= '0;
            r_left_w    <= '0;
            r_left_b    <= '0;
            r_fell_w    <= 1'b0;
            r_fell_b    <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_timed  <= n_timed;
                    r_halted <= n_halted;
                    r_act    <= n_act;
                    r_stamp  <= n_stamp;
                    r_left_w <= n_left_w;
                    r_left_b <= n_left_b;
                    r_fell_w <= n_fell_w;
                    r_fell_b <= n_fell_b;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance && r_in_valid) begin
            r_out.white_left_ms <= 32'(n_left_w);
            r_out.black_left_ms <= 32'(n_left_b);
            r_out.running_side  <= n_act;
            r_out.is_paused     <= n_halted;
            r_out.white_fell    <= n_fell_w;
            r_out.black_fell    <= n_fell_b;
            r_out.timed_game    <= n_timed;
        end
    end

endmodule

>>> sim/tb_top.sv
// Testbench for the two-sided game clock: directed event table, then random games vs predictor.
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 10;
    localparam int unsigned LONG_HOLD   = 60;
    localparam int unsigned PHASE_ITEMS = 190;

    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam logic       WHITE       = 1'b0;
    localparam logic       BLACK       = 1'b1;

    typedef struct packed {
        tsgc_pkg::t_in  ev;
        logic           fixed;
        tsgc_pkg::t_out want;
    } t_row;

    localparam tsgc_pkg::t_out ZERO_OUT    = '0;
    localparam tsgc_pkg::t_out START_BLACK = '{tsgc_pkg::RST_INIT_MS, tsgc_pkg::RST_INIT_MS,
                                               BLACK, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam tsgc_pkg::t_out START_WHITE = '{tsgc_pkg::RST_INIT_MS, tsgc_pkg::RST_INIT_MS,
                                               WHITE, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam int unsigned N_DIRECTED = 24;

    // runs right after reset, so the default register values apply
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{'{tsgc_pkg::MODE_TICK,   32'd0,          WHITE}, 1'b1, ZERO_OUT},
        '{'{tsgc_pkg::MODE_SWITCH, 32'd100,        BLACK}, 1'b1, ZERO_OUT},
        '{'{tsgc_pkg::MODE_INC,    32'd200,        BLACK}, 1'b1, ZERO_OUT},
        '{'{tsgc_pkg::MODE_PAUSE,  32'd300,        WHITE}, 1'b1, ZERO_OUT},
        '{'{tsgc_pkg::MODE_START,  32'd1000,       BLACK}, 1'b1, START_BLACK},
        '{'{tsgc_pkg::MODE_TICK,   32'd1000,       WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_TICK,   32'd1500,       WHITE}, 1'b0, ZERO_OUT},
        '{'{MODE_SPARE6,           32'hFFFF_FFFF,  BLACK}, 1'b0, ZERO_OUT},
        '{'{MODE_SPARE7,           32'd0,          WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_SWITCH, 32'd2000,       WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_INC,    32'd2100,       WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_PAUSE,  32'd3000,       WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_PAUSE,  32'd3500,       BLACK}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_TICK,   32'd9000,       WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_SWITCH, 32'd10000,      WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_RESUME, 32'd20000,      WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_RESUME, 32'd20500,      BLACK}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_TICK,   32'hFFFF_FFF0,  WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_INC,    32'hFFFF_FFF1,  BLACK}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_TICK,   32'h0000_0010,  WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_SWITCH, 32'h0000_0020,  WHITE}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_START,  32'hFFFF_FFFF,  WHITE}, 1'b1, START_WHITE},
        '{'{tsgc_pkg::MODE_TICK,   32'd5,          BLACK}, 1'b0, ZERO_OUT},
        '{'{tsgc_pkg::MODE_SWITCH, 32'h7FFF_FFFF,  BLACK}, 1'b0, ZERO_OUT}
    };

    localparam int unsigned N_SETUPS = 6;
    localparam tsgc_pkg::t_cfg SETUPS [N_SETUPS] = '{
        '{1'b1, 32'd5000,      32'd300},
        '{1'b1, 32'd0,         32'd0},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{1'b0, 32'd1000,      32'd500},
        '{1'b1, 32'd20000,     32'hFFFF_FFFF},
        '{1'b1, 32'd3000,      32'd1000}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    tsgc_pkg::t_in                  i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    tsgc_pkg::t_out                 o_out_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tsgc_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    two_side_game_clock dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // register copies and game state of the predictor
    logic        cfg_timed_on;
    logic [31:0] cfg_init_ms;
    logic [31:0] cfg_inc_ms;
    logic        gc_timed;
    logic        gc_halted;
    logic        gc_side;
    logic [31:0] gc_stamp;
    logic [31:0] gc_left [2];
    logic        gc_fell [2];

    tsgc_pkg::t_out clock_q [$];
    tsgc_pkg::t_out head_want;
    int             errors;
    int             cycles;
    bit             idle_on;
    bit             no_gap;
    bit             long_hold_req;

    function automatic void charge_running(input logic [31:0] now);
        logic [31:0] elapsed;
        if (!gc_timed || gc_halted) return;
        elapsed  = now - gc_stamp;  // wraps modulo 2^32
        gc_stamp = now;
        if (elapsed == '0 || gc_fell[gc_side]) return;
        if (elapsed >= gc_left[gc_side]) begin
            gc_left[gc_side] = '0;
            gc_fell[gc_side] = 1'b1;
        end else begin
            gc_left[gc_side] = gc_left[gc_side] - elapsed;
        end
    endfunction

    function automatic tsgc_pkg::t_out clock_after(input tsgc_pkg::t_in ev);
        logic [32:0]    sum;
        tsgc_pkg::t_out r;
        case (ev.mode)
            tsgc_pkg::MODE_TICK: charge_running(ev.now_ms);
            tsgc_pkg::MODE_SWITCH: if (gc_timed) begin
                charge_running(ev.now_ms);
                gc_side  = ~gc_side;
                gc_stamp = ev.now_ms;
            end
            tsgc_pkg::MODE_INC: if (gc_timed && !gc_fell[ev.side]) begin
                sum = {1'b0, gc_left[ev.side]} + {1'b0, cfg_inc_ms};
                gc_left[ev.side] = sum[32] ? '1 : sum[31:0];
            end
            tsgc_pkg::MODE_PAUSE: if (gc_timed && !gc_halted) begin
                charge_running(ev.now_ms);
                gc_halted = 1'b1;
            end
            tsgc_pkg::MODE_RESUME: if (gc_timed && gc_halted) begin
                gc_halted = 1'b0;
                gc_stamp  = ev.now_ms;
            end
            tsgc_pkg::MODE_START: begin
                gc_timed   = cfg_timed_on;
                gc_halted  = 1'b0;
                gc_side    = cfg_timed_on ? ev.side : WHITE;
                gc_stamp   = cfg_timed_on ? ev.now_ms : '0;
                gc_left[0] = cfg_timed_on ? cfg_init_ms : '0;
                gc_left[1] = cfg_timed_on ? cfg_init_ms : '0;
                gc_fell[0] = 1'b0;
                gc_fell[1] = 1'b0;
            end
            default: ;
        endcase
        r.white_left_ms = gc_left[0];
        r.black_left_ms = gc_left[1];
        r.running_side  = gc_side;
        r.is_paused     = gc_halted;
        r.white_fell    = gc_fell[0];
        r.black_fell    = gc_fell[1];
        r.timed_game    = gc_timed;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d (0x%h), got %0d (0x%h)",
                     $time, name, want, want, got, got);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (clock_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: %p", $time, o_out_data);
                errors++;
            end else begin
                head_want = clock_q.pop_front();
                check_field("white_left_ms", head_want.white_left_ms,
                            o_out_data.white_left_ms);
                check_field("black_left_ms", head_want.black_left_ms,
                            o_out_data.black_left_ms);
                check_field("running_side", 32'(head_want.running_side),
                            32'(o_out_data.running_side));
                check_field("is_paused", 32'(head_want.is_paused),
                            32'(o_out_data.is_paused));
                check_field("white_fell", 32'(head_want.white_fell),
                            32'(o_out_data.white_fell));
                check_field("black_fell", 32'(head_want.black_fell),
                            32'(o_out_data.black_fell));
                check_field("timed_game", 32'(head_want.timed_game),
                            32'(o_out_data.timed_game));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, clock_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stall: random bursts, plus a long hold-off on request
    initial begin : out_side
        int burst;
        burst = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                burst = LONG_HOLD;
            end else if (burst == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 18);
            end
            if (burst > 0) begin
                i_out_stall <= 1'b1;
                burst--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_event(input tsgc_pkg::t_in ev, input logic fixed,
                              input tsgc_pkg::t_out want);
        tsgc_pkg::t_out pred;
        if (idle_on && !no_gap && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        pred = clock_after(ev);
        clock_q.push_back(fixed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (clock_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tsgc_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tsgc_pkg::REG_TIME_CTRL: cfg_timed_on = value[0];
            tsgc_pkg::REG_INIT_MS:   cfg_init_ms  = value;
            tsgc_pkg::REG_INC_MS:    cfg_inc_ms   = value;
            default: ;
        endcase
    endtask

    task automatic play_games(input int n_items, input bit quiet);
        tsgc_pkg::t_in ev;
        logic [31:0]   now;
        int            pick;
        now     = $urandom;
        idle_on = !quiet;
        for (int k = 0; k < n_items; k++) begin
            if (!quiet && k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (!quiet && k == 50) begin
                long_hold_req = 1'b1;
                no_gap = 1'b1;
            end
            if (k == 80) no_gap = 1'b0;
            if (!quiet && k == 120) begin
                i_in_valid <= 1'b0;
                wait_drained();
                @(negedge i_clk);
            end
            case ($urandom_range(0, 9))
                0: ;
                9: now = $urandom;
                7, 8: now = now + $urandom_range(1, 200000);
                default: now = now + $urandom_range(1, 5000);
            endcase
            pick = $urandom_range(0, 99);
            if (k == 0 || pick < 3) ev.mode = tsgc_pkg::MODE_START;
            else if (pick < 40) ev.mode = tsgc_pkg::MODE_TICK;
            else if (pick < 68) ev.mode = tsgc_pkg::MODE_SWITCH;
            else if (pick < 80) ev.mode = tsgc_pkg::MODE_INC;
            else if (pick < 89) ev.mode = tsgc_pkg::MODE_PAUSE;
            else if (pick < 97) ev.mode = tsgc_pkg::MODE_RESUME;
            else ev.mode = $urandom_range(0, 1) ? MODE_SPARE7 : MODE_SPARE6;
            ev.now_ms = now;
            ev.side   = 1'($urandom_range(0, 1));
            send_event(ev, 1'b0, ZERO_OUT);
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_on       = 1'b1;
        no_gap        = 1'b0;
        long_hold_req = 1'b0;
        errors        = 0;
        cycles        = 0;
        cfg_timed_on  = tsgc_pkg::RST_TIME_CTRL;
        cfg_init_ms   = tsgc_pkg::RST_INIT_MS;
        cfg_inc_ms    = tsgc_pkg::RST_INC_MS;
        gc_timed      = 1'b0;
        gc_halted     = 1'b0;
        gc_side       = WHITE;
        gc_stamp      = '0;
        gc_left[0]    = '0;
        gc_left[1]    = '0;
        gc_fell[0]    = 1'b0;
        gc_fell[1]    = 1'b0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_event(DIRECTED[r].ev, DIRECTED[r].fixed, DIRECTED[r].want);
        end

        for (int p = 0; p < N_SETUPS; p++) begin
            i_in_valid <= 1'b0;
            wait_drained();
            repeat (TAIL_CYCLES) @(negedge i_clk);
            write_reg(tsgc_pkg::REG_TIME_CTRL, {31'd0, SETUPS[p].time_ctrl});
            write_reg(tsgc_pkg::REG_INIT_MS, SETUPS[p].init_ms);
            write_reg(tsgc_pkg::REG_INC_MS, SETUPS[p].inc_ms);
            play_games(PHASE_ITEMS, p == N_SETUPS - 1);
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
